// ===== rtl/core/ssc_pkg.sv =====
// package for the salsa20 / chacha20 byte stream cipher
package ssc_pkg;

  localparam int RoundCount = 20;
  localparam int RndW       = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [31:0] Sig0 = 32'h61707865;
  localparam logic [31:0] Sig1 = 32'h3320646e;
  localparam logic [31:0] Sig2 = 32'h79622d32;
  localparam logic [31:0] Sig3 = 32'h6b206574;
  localparam logic [31:0] Tau1 = 32'h3120646e;
  localparam logic [31:0] Tau2 = 32'h79622d36;

  localparam logic [CfgIdxW-1:0] RegCipherSel = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLen    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyLo     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyMidLo  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyMidHi  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKeyHi     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNonce     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCtrStart  = 3'd7;

  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic        chacha;
    logic        key32;
    logic [255:0] key;
    logic [63:0] nonce;
    logic [63:0] counter;
  } blk_cfg_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // index of the quarter-round word: qi (0..3) of lane ln for odd/even round
  function automatic logic [3:0] qidx(input logic chacha, input logic odd,
                                      input logic [1:0] ln, input logic [1:0] qi);
    logic [1:0] r;
    begin
      if (chacha) begin
        if (odd) r = ln + qi;
        else     r = ln;
        qidx = {qi, r};
      end else begin
        if (odd) qidx = {ln, 2'(ln + qi)};
        else     qidx = {2'(ln + qi), ln};
      end
    end
  endfunction

endpackage

// ===== rtl/core/ssc_core.sv =====
// block function: one quarter-round per cycle over a 16-word state
module ssc_core
  import ssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  blk_cfg_t cfg,
  output logic     done,
  output state_t   ks
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_ADD  = 4'b0100,
    S_DONE = 4'b1000
  } st_t;

  st_t             st_r, st_nxt;
  state_t          x_r, x_nxt, init_r, init_nxt, ks_r, ks_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [1:0]      ln_r, ln_nxt;
  logic            chacha_r, chacha_nxt;

  state_t     init_c;
  logic [7:0][31:0] key;
  logic [31:0] c1, c2;
  logic [3:0] i0, i1, i2, i3;
  logic [31:0] a, b, c, d, na, nb, nc, nd;

  always_comb begin
    key[3:0] = cfg.key[127:0];
    if (cfg.key32) begin
      key[7:4] = cfg.key[255:128];
      c1 = Sig1;
      c2 = Sig2;
    end else begin
      key[7:4] = cfg.key[127:0];
      c1 = Tau1;
      c2 = Tau2;
    end
    if (cfg.chacha) begin
      init_c[0] = Sig0; init_c[1] = c1; init_c[2] = c2; init_c[3] = Sig3;
      for (int i = 0; i < 8; i++) init_c[4+i] = key[i];
      init_c[12] = cfg.counter[31:0]; init_c[13] = cfg.counter[63:32];
      init_c[14] = cfg.nonce[31:0];   init_c[15] = cfg.nonce[63:32];
    end else begin
      init_c[0] = Sig0; init_c[5] = c1; init_c[10] = c2; init_c[15] = Sig3;
      for (int i = 0; i < 4; i++) begin
        init_c[1+i]  = key[i];
        init_c[11+i] = key[4+i];
      end
      init_c[6] = cfg.nonce[31:0];   init_c[7] = cfg.nonce[63:32];
      init_c[8] = cfg.counter[31:0]; init_c[9] = cfg.counter[63:32];
    end
  end

  always_comb begin
    i0 = qidx(chacha_r, rnd_r[0], ln_r, 2'd0);
    i1 = qidx(chacha_r, rnd_r[0], ln_r, 2'd1);
    i2 = qidx(chacha_r, rnd_r[0], ln_r, 2'd2);
    i3 = qidx(chacha_r, rnd_r[0], ln_r, 2'd3);
    a = x_r[i0]; b = x_r[i1]; c = x_r[i2]; d = x_r[i3];
    if (chacha_r) begin
      na = a + b;  nd = rotl(d ^ na, 16);
      nc = c + nd; nb = rotl(b ^ nc, 12);
      na = na + nb; nd = rotl(nd ^ na, 8);
      nc = nc + nd; nb = rotl(nb ^ nc, 7);
    end else begin
      na = a;
      nb = b ^ rotl(a + d, 7);
      nc = c ^ rotl(nb + a, 9);
      nd = d ^ rotl(nc + nb, 13);
      na = a ^ rotl(nd + nc, 18);
    end
  end

  always_comb begin
    st_nxt = st_r; x_nxt = x_r; init_nxt = init_r; ks_nxt = ks_r;
    rnd_nxt = rnd_r; ln_nxt = ln_r; chacha_nxt = chacha_r;
    case (st_r)
      S_IDLE, S_DONE: begin
        if (start) begin
          x_nxt = init_c; init_nxt = init_c; chacha_nxt = cfg.chacha;
          rnd_nxt = '0; ln_nxt = '0; st_nxt = S_RUN;
        end
      end
      S_RUN: begin
        x_nxt[i0] = na; x_nxt[i1] = nb; x_nxt[i2] = nc; x_nxt[i3] = nd;
        ln_nxt = ln_r + 2'd1;
        if (ln_r == 2'd3) begin
          rnd_nxt = rnd_r + 1'b1;
          if (rnd_r == RndW'(RoundCount - 1)) st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 16; i++) ks_nxt[i] = x_r[i] + init_r[i];
        st_nxt = S_DONE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
    x_r <= x_nxt; init_r <= init_nxt; ks_r <= ks_nxt;
    rnd_r <= rnd_nxt; ln_r <= ln_nxt; chacha_r <= chacha_nxt;
  end

  assign done = (st_r == S_DONE);
  assign ks   = ks_r;

endmodule

// ===== rtl/core/salsa_chacha_stream_cipher_unit.sv =====
// top level of the salsa20 / chacha20 byte stream cipher
// Each input beat carries one byte, which is xored with the keystream and
// returned as one output beat. A byte that needs a fresh 64-byte block (first
// byte, start_of_call, or every 64th byte) waits for the block unit, which
// runs one quarter-round per cycle and then adds the input state; other
// bytes are xored with the current block directly, and a byte is taken only
// while no output beat is held by out_stall.
module salsa_chacha_stream_cipher_unit
  import ssc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_in,
  input  logic                in_start_of_call,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_out
);

  logic         chacha_r, key32_r;
  logic [255:0] key_r;
  logic [63:0]  nonce_r, ctr_start_r, ctr_r, ctr_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic         ready_r, ready_nxt;
  logic         wait_r, wait_nxt;
  logic [7:0]   byte_r, byte_nxt;
  logic         ov_r, ov_nxt;
  logic [7:0]   od_r, od_nxt;

  blk_cfg_t bcfg;
  logic     start, done, acc, need, out_free;
  state_t   ks;
  logic [63:0] ctr_use;
  logic [7:0]  ksb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chacha_r <= 1'b0; key32_r <= 1'b1; key_r <= '0;
      nonce_r <= '0; ctr_start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCipherSel: chacha_r <= cfg_data[0];
        RegKeyLen:    key32_r <= cfg_data[0];
        RegKeyLo:     key_r[63:0] <= cfg_data;
        RegKeyMidLo:  key_r[127:64] <= cfg_data;
        RegKeyMidHi:  key_r[191:128] <= cfg_data;
        RegKeyHi:     key_r[255:192] <= cfg_data;
        RegNonce:     nonce_r <= cfg_data;
        RegCtrStart:  ctr_start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !ov_r || !out_stall;
  assign in_stall = wait_r || !out_free;
  assign acc      = in_valid && !in_stall;
  assign need     = in_start_of_call || !ready_r || (pos_r == 6'd0);
  assign ctr_use  = in_restart ? ctr_start_r : ctr_r;
  assign start    = acc && need;

  assign bcfg = '{chacha: chacha_r, key32: key32_r, key: key_r,
                  nonce: nonce_r, counter: ctr_use};

  ssc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cfg   (bcfg),
    .done  (done),
    .ks    (ks)
  );

  always_comb begin
    ksb = ks[pos_r[5:2]][8*pos_r[1:0] +: 8];
  end

  always_comb begin
    ctr_nxt = ctr_r; pos_nxt = pos_r; ready_nxt = ready_r;
    wait_nxt = wait_r; byte_nxt = byte_r;
    ov_nxt = ov_r && out_stall; od_nxt = od_r;
    if (acc) begin
      ctr_nxt = ctr_use;
      if (need) begin
        ctr_nxt = ctr_use + 64'd1;
        pos_nxt = 6'd0; ready_nxt = 1'b1;
        wait_nxt = 1'b1; byte_nxt = in_data_in;
      end else begin
        ov_nxt = 1'b1; od_nxt = in_data_in ^ ksb;
        pos_nxt = pos_r + 6'd1;
      end
    end else if (wait_r && done && out_free) begin
      ov_nxt = 1'b1; od_nxt = byte_r ^ ksb;
      pos_nxt = pos_r + 6'd1; wait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0; pos_r <= '0; ready_r <= 1'b0; wait_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      ctr_r <= ctr_nxt; pos_r <= pos_nxt; ready_r <= ready_nxt;
      wait_r <= wait_nxt; ov_r <= ov_nxt;
    end
    byte_r <= byte_nxt; od_r <= od_nxt;
  end

  assign out_valid    = ov_r;
  assign out_data_out = od_r;

endmodule

// ===== tb/tb.sv =====
// testbench for the salsa20 / chacha20 byte stream cipher unit
module tb;
  import ssc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCol[16]  = '{0,4,8,12, 5,9,13,1, 10,14,2,6, 15,3,7,11};
  localparam int SRow[16]  = '{0,1,2,3, 5,6,7,4, 10,11,8,9, 15,12,13,14};
  localparam int CCol[16]  = '{0,4,8,12, 1,5,9,13, 2,6,10,14, 3,7,11,15};
  localparam int CDiag[16] = '{0,5,10,15, 1,6,11,12, 2,7,8,13, 3,4,9,14};

  typedef struct {
    logic [7:0] data;
    logic       soc;
    logic       rs;
    bit         known;
    logic [7:0] known_out;
  } byte_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_data_in = '0;
  logic                in_start_of_call = 1'b0;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_data_out;

  // shadow of the cipher settings and stream state
  logic        sel_chacha;
  logic        key_full;
  logic [63:0] key_reg [4];
  logic [63:0] nonce_reg;
  logic [63:0] ctr_start_reg;
  logic [63:0] blk_ctr;
  logic [31:0] ks_words [16];
  logic [5:0]  ks_pos;
  bit          ks_ready;

  logic [7:0] cipher_bytes_due [$];
  int         errs = 0;
  bit         calm = 0;
  int         stall_left = 0;

  salsa_chacha_stream_cipher_unit dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void make_keystream_block();
    logic [31:0] kw [8];
    logic [31:0] init [16];
    logic [31:0] x [16];
    logic [31:0] c1, c2, a, b, c, d;
    int q [4];
    for (int i = 0; i < 4; i++) begin
      kw[i] = key_reg[i/2][32*(i%2) +: 32];
      kw[i+4] = key_full ? key_reg[2 + i/2][32*(i%2) +: 32] : kw[i];
    end
    c1 = key_full ? Sig1 : Tau1;
    c2 = key_full ? Sig2 : Tau2;
    if (sel_chacha) begin
      init[0] = Sig0; init[1] = c1; init[2] = c2; init[3] = Sig3;
      for (int i = 0; i < 8; i++) init[4+i] = kw[i];
      init[12] = blk_ctr[31:0]; init[13] = blk_ctr[63:32];
      init[14] = nonce_reg[31:0]; init[15] = nonce_reg[63:32];
    end else begin
      init[0] = Sig0; init[5] = c1; init[10] = c2; init[15] = Sig3;
      for (int i = 0; i < 4; i++) begin
        init[1+i] = kw[i];
        init[11+i] = kw[4+i];
      end
      init[6] = nonce_reg[31:0]; init[7] = nonce_reg[63:32];
      init[8] = blk_ctr[31:0]; init[9] = blk_ctr[63:32];
    end
    x = init;
    for (int r = 0; r < RoundCount; r++) begin
      for (int l = 0; l < 4; l++) begin
        for (int j = 0; j < 4; j++) begin
          if (sel_chacha) q[j] = r[0] ? CDiag[4*l+j] : CCol[4*l+j];
          else            q[j] = r[0] ? SRow[4*l+j]  : SCol[4*l+j];
        end
        if (sel_chacha) begin
          a = x[q[0]]; b = x[q[1]]; c = x[q[2]]; d = x[q[3]];
          a = a + b; d = rol32(d ^ a, 16);
          c = c + d; b = rol32(b ^ c, 12);
          a = a + b; d = rol32(d ^ a, 8);
          c = c + d; b = rol32(b ^ c, 7);
          x[q[0]] = a; x[q[1]] = b; x[q[2]] = c; x[q[3]] = d;
        end else begin
          x[q[1]] ^= rol32(x[q[0]] + x[q[3]], 7);
          x[q[2]] ^= rol32(x[q[1]] + x[q[0]], 9);
          x[q[3]] ^= rol32(x[q[2]] + x[q[1]], 13);
          x[q[0]] ^= rol32(x[q[3]] + x[q[2]], 18);
        end
      end
    end
    for (int i = 0; i < 16; i++) ks_words[i] = x[i] + init[i];
    blk_ctr = blk_ctr + 64'd1;
  endfunction

  function automatic logic [7:0] cipher_byte(logic [7:0] d, logic soc, logic rs);
    logic [31:0] w;
    if (rs) blk_ctr = ctr_start_reg;
    if (soc || !ks_ready || ks_pos == 6'd0) begin
      make_keystream_block();
      ks_pos = 6'd0;
      ks_ready = 1;
    end
    w = ks_words[ks_pos[5:2]];
    cipher_byte = d ^ w[8*ks_pos[1:0] +: 8];
    ks_pos = ks_pos + 6'd1;
  endfunction

  // caller lowers cfg_we after the last write of a group
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegCipherSel: sel_chacha = val[0];
      RegKeyLen:    key_full = val[0];
      RegKeyLo:     key_reg[0] = val;
      RegKeyMidLo:  key_reg[1] = val;
      RegKeyMidHi:  key_reg[2] = val;
      RegKeyHi:     key_reg[3] = val;
      RegNonce:     nonce_reg = val;
      RegCtrStart:  ctr_start_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_byte(byte_row_t row);
    int gap;
    logic [7:0] want;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_in <= row.data;
    in_start_of_call <= row.soc;
    in_restart <= row.rs;
    do @(posedge clk); while (in_stall);
    want = cipher_byte(row.data, row.soc, row.rs);
    cipher_bytes_due.push_back(row.known ? row.known_out : want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_bytes_due.size() == 0) begin
        $display("%0t: unexpected beat, actual %02h", $time, out_data_out);
        errs++;
      end else begin
        if (out_data_out !== cipher_bytes_due[0]) begin
          $display("%0t: data_out expected %02h actual %02h", $time,
                   cipher_bytes_due[0], out_data_out);
          errs++;
        end
        void'(cipher_bytes_due.pop_front());
      end
    end
  end

  initial begin
    byte_row_t directed [] = '{
      '{8'h00, 1, 0, 1, 8'h76}, '{8'h00, 0, 0, 1, 8'hb8},
      '{8'h00, 0, 0, 1, 8'he0}, '{8'hff, 0, 0, 1, 8'h52},
      '{8'h00, 0, 1, 0, 8'h00}, '{8'hff, 0, 0, 0, 8'h00},
      '{8'h00, 1, 1, 1, 8'h76}, '{8'h80, 0, 0, 1, 8'h38},
      '{8'h00, 1, 0, 0, 8'h00}, '{8'h01, 0, 0, 0, 8'h00},
      '{8'h00, 0, 1, 0, 8'h00}, '{8'hff, 1, 1, 1, 8'h89},
      '{8'h55, 0, 0, 0, 8'h00}, '{8'haa, 0, 0, 0, 8'h00},
      '{8'h7f, 1, 0, 0, 8'h00}, '{8'hfe, 0, 1, 0, 8'h00}
    };
    byte_row_t row;
    int call_left;
    sel_chacha = 0; key_full = 1;
    foreach (key_reg[i]) key_reg[i] = '0;
    nonce_reg = '0; ctr_start_reg = '0;
    blk_ctr = '0; ks_pos = '0; ks_ready = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(RegCipherSel, 64'd1);
    cfg_we <= 1'b0;
    foreach (directed[i]) send_byte(directed[i]);
    // full crossing of the 64-byte boundary
    for (int i = 0; i < 70; i++) send_byte('{8'($urandom), 0, 0, 0, 8'h00});
    drain();

    call_left = 0;
    for (int ph = 0; ph < 9; ph++) begin
      cfg_write(RegCipherSel, ph < 4 ? 64'(ph[0]) : 64'($urandom_range(0, 1)));
      cfg_write(RegKeyLen, ph < 4 ? 64'(ph[1]) : 64'($urandom_range(0, 1)));
      cfg_write(RegKeyLo, ph == 1 ? '1 : rand64());
      cfg_write(RegKeyMidLo, ph == 1 ? '1 : rand64());
      cfg_write(RegKeyMidHi, ph == 1 ? '1 : rand64());
      cfg_write(RegKeyHi, ph == 1 ? '1 : rand64());
      cfg_write(RegNonce, ph == 1 ? '1 : rand64());
      cfg_write(RegCtrStart, ph == 2 ? '1 : ph == 3 ? 64'hffff_ffff : rand64());
      cfg_we <= 1'b0;
      if (ph == 8) calm = 1;
      for (int i = 0; i < 115; i++) begin
        row.data = 8'($urandom);
        row.soc = (call_left == 0) || ($urandom_range(0, 40) == 0);
        if (row.soc) call_left = $urandom_range(1, 150);
        call_left--;
        row.rs = (row.soc && $urandom_range(0, 3) == 0) || $urandom_range(0, 30) == 0;
        row.known = 0;
        row.known_out = '0;
        send_byte(row);
      end
      drain();
    end

    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssc_pkg.sv
rtl/core/ssc_core.sv
rtl/core/salsa_chacha_stream_cipher_unit.sv
tb/tb.sv
